FILE: rtl/core/todpt_pkg.sv
// ----------------------------------------------------------------------------
// todpt_pkg: shared types and constants for the time-of-day palette tint
// Keyframe table, tint constants, reciprocal multipliers and pipeline records.
// ----------------------------------------------------------------------------
package todpt_pkg;

  localparam int KEY_COUNT  = 6;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 11;

  typedef logic [4:0]  chan_t;
  typedef logic [10:0] minute_t;
  typedef logic [2:0]  key_idx_t;
  typedef logic [6:0]  frac_t;
  typedef logic [11:0] span_t;

  // last member sits in the low bits: red 4:0, green 9:5, blue 14:10
  typedef struct packed {
    chan_t b;
    chan_t g;
    chan_t r;
  } rgb_t;

  typedef enum logic [1:0] {
    TC_DAWN  = 2'd0,
    TC_DAY   = 2'd1,
    TC_DUSK  = 2'd2,
    TC_NIGHT = 2'd3
  } tcode_t;

  localparam logic [CFG_IDX_W-1:0] REG_MINUTE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_EN = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAVE    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BATTLE  = 4'd3;

  localparam rgb_t  CAVE_TINT  = '{b: 5'd22, g: 5'd16, r: 5'd18};
  localparam rgb_t  WHITE_TINT = '{b: 5'd31, g: 5'd31, r: 5'd31};
  localparam frac_t LERP_FULL  = 7'd100;

  // floor(n / span) for n = offset * 100, done as (offset*5) * magic >> 16
  localparam int SEG_SHIFT = 16;
  // floor(x / 100) = x * 2622 >> 18, exact for x below 4096
  localparam logic [11:0] RECIP_100 = 12'd2622;
  localparam int          R100_SHIFT = 18;
  // floor(x / 31) = x * 2115 >> 16, exact for x below 1024
  localparam logic [11:0] RECIP_31 = 12'd2115;
  localparam int          R31_SHIFT = 16;

  typedef struct packed {
    logic tint_en;
    logic cave;
    logic battle;
  } mode_t;

  typedef struct packed {
    rgb_t     colour;
    logic     last;
    mode_t    mode;
    key_idx_t ka;
    key_idx_t kb;
    span_t    span_n;
  } seg_item_t;

  typedef struct packed {
    rgb_t   colour;
    logic   last;
    logic   tint_en;
    tcode_t code;
    rgb_t   tone;
  } tone_item_t;

  function automatic minute_t key_time(key_idx_t i);
    case (i)
      3'd0:    key_time = 11'd300;
      3'd1:    key_time = 11'd360;
      3'd2:    key_time = 11'd480;
      3'd3:    key_time = 11'd1140;
      3'd4:    key_time = 11'd1260;
      default: key_time = 11'd1380;
    endcase
  endfunction

  function automatic rgb_t key_rgb(key_idx_t i);
    case (i)
      3'd1:       key_rgb = '{b: 5'd12, g: 5'd19, r: 5'd31};
      3'd2, 3'd3: key_rgb = WHITE_TINT;
      3'd4:       key_rgb = '{b: 5'd16, g: 5'd16, r: 5'd31};
      default:    key_rgb = '{b: 5'd21, g: 5'd15, r: 5'd9};
    endcase
  endfunction

  function automatic tcode_t key_code(key_idx_t i);
    case (i)
      3'd1:       key_code = TC_DAWN;
      3'd2, 3'd3: key_code = TC_DAY;
      3'd4:       key_code = TC_DUSK;
      default:    key_code = TC_NIGHT;
    endcase
  endfunction

  // reciprocal of span/20 for the segment that starts at key i
  function automatic logic [14:0] seg_magic(key_idx_t i);
    case (i)
      3'd0:       seg_magic = 15'd21846;
      3'd1, 3'd3,
      3'd4:       seg_magic = 15'd10923;
      3'd2:       seg_magic = 15'd1986;
      default:    seg_magic = 15'd0;
    endcase
  endfunction

endpackage

FILE: rtl/core/todpt_seg.sv
// ----------------------------------------------------------------------------
// todpt_seg: keyframe segment lookup stage
// Finds the keyframe pair around the minute and the scaled offset into it.
// ----------------------------------------------------------------------------
module todpt_seg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  todpt_pkg::rgb_t     in_colour,
  input  logic                in_last,
  input  todpt_pkg::mode_t    in_mode,
  input  todpt_pkg::minute_t  minute,
  output logic                out_valid,
  input  logic                out_ready,
  output todpt_pkg::seg_item_t out_item
);
  import todpt_pkg::*;

  logic      vld_r;
  logic      vld_nxt;
  seg_item_t item_r;
  seg_item_t item_nxt;
  key_idx_t  ka;
  logic      flat;
  minute_t   offset;

  assign in_ready = !vld_r || out_ready;

  always_comb begin
    ka = '0;
    for (int i = 0; i < KEY_COUNT; i++) begin
      if (minute >= key_time(key_idx_t'(i))) begin
        ka = key_idx_t'(i);
      end
    end
    // before the first key or from the last one on the edge colour holds
    flat   = (minute < key_time('0)) || (ka == key_idx_t'(KEY_COUNT - 1));
    offset = minute - key_time(ka);

    item_nxt.colour = in_colour;
    item_nxt.last   = in_last;
    item_nxt.mode   = in_mode;
    item_nxt.ka     = ka;
    item_nxt.kb     = flat ? ka : ka + 3'd1;
    item_nxt.span_n = flat ? '0 : {offset[9:0], 2'b00} + {2'b00, offset[9:0]};
  end

  always_comb begin
    vld_nxt = in_ready ? in_valid : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_item  = item_r;

  a_seg_pair: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> ((item_r.kb == item_r.ka) && (item_r.span_n == '0))
           || (item_r.kb == item_r.ka + 3'd1))
    else $error("keyframe pair out of order");

endmodule

FILE: rtl/core/todpt_lerp.sv
// ----------------------------------------------------------------------------
// todpt_lerp: keyframe interpolation pipeline
// Percentage along the segment, weighted channel sums, divide by 100, cave mux.
// ----------------------------------------------------------------------------
module todpt_lerp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  todpt_pkg::seg_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output todpt_pkg::tone_item_t out_item
);
  import todpt_pkg::*;

  typedef struct packed {
    rgb_t     colour;
    logic     last;
    mode_t    mode;
    key_idx_t ka;
    key_idx_t kb;
    frac_t    t;
  } frac_item_t;

  typedef struct packed {
    rgb_t        colour;
    logic        last;
    mode_t       mode;
    tcode_t      code;
    logic [11:0] sum_b;
    logic [11:0] sum_g;
    logic [11:0] sum_r;
  } sum_item_t;

  logic       vld_a_r, vld_b_r, vld_c_r;
  logic       vld_a_nxt, vld_b_nxt, vld_c_nxt;
  logic       rdy_a, rdy_b, rdy_c;
  frac_item_t item_a_r, item_a_nxt;
  sum_item_t  item_b_r, item_b_nxt;
  tone_item_t item_c_r, item_c_nxt;
  logic [26:0] t_prod;
  rgb_t       ca, cb, lerp_tone;

  function automatic logic [11:0] lerp_sum(chan_t a, chan_t b, frac_t t);
    logic [11:0] wa;
    logic [11:0] wb;
    wa = 12'(a) * 12'(LERP_FULL - t);
    wb = 12'(b) * 12'(t);
    lerp_sum = wa + wb;
  endfunction

  function automatic chan_t div100(logic [11:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'(RECIP_100);
    div100 = p[R100_SHIFT +: 5];
  endfunction

  assign rdy_c    = !vld_c_r || out_ready;
  assign rdy_b    = !vld_b_r || rdy_c;
  assign rdy_a    = !vld_a_r || rdy_b;
  assign in_ready = rdy_a;

  // stage a: percentage along the segment
  always_comb begin
    t_prod = 27'(in_item.span_n) * 27'(seg_magic(in_item.ka));
    item_a_nxt.colour = in_item.colour;
    item_a_nxt.last   = in_item.last;
    item_a_nxt.mode   = in_item.mode;
    item_a_nxt.ka     = in_item.ka;
    item_a_nxt.kb     = in_item.kb;
    item_a_nxt.t      = t_prod[SEG_SHIFT +: 7];
  end

  // stage b: weighted sums per channel
  always_comb begin
    ca = key_rgb(item_a_r.ka);
    cb = key_rgb(item_a_r.kb);
    item_b_nxt.colour = item_a_r.colour;
    item_b_nxt.last   = item_a_r.last;
    item_b_nxt.mode   = item_a_r.mode;
    item_b_nxt.code   = key_code(item_a_r.ka);
    item_b_nxt.sum_r  = lerp_sum(ca.r, cb.r, item_a_r.t);
    item_b_nxt.sum_g  = lerp_sum(ca.g, cb.g, item_a_r.t);
    item_b_nxt.sum_b  = lerp_sum(ca.b, cb.b, item_a_r.t);
  end

  // stage c: scale back and apply the cave override
  always_comb begin
    lerp_tone.r = div100(item_b_r.sum_r);
    lerp_tone.g = div100(item_b_r.sum_g);
    lerp_tone.b = div100(item_b_r.sum_b);
    item_c_nxt.colour  = item_b_r.colour;
    item_c_nxt.last    = item_b_r.last;
    item_c_nxt.tint_en = item_b_r.mode.tint_en;
    item_c_nxt.code    = item_b_r.code;
    if (item_b_r.mode.cave) begin
      item_c_nxt.tone = item_b_r.mode.battle ? WHITE_TINT : CAVE_TINT;
    end else begin
      item_c_nxt.tone = lerp_tone;
    end
  end

  always_comb begin
    vld_a_nxt = rdy_a ? in_valid : vld_a_r;
    vld_b_nxt = rdy_b ? vld_a_r  : vld_b_r;
    vld_c_nxt = rdy_c ? vld_b_r  : vld_c_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
    end else begin
      vld_a_r <= vld_a_nxt;
      vld_b_r <= vld_b_nxt;
      vld_c_r <= vld_c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      item_a_r <= item_a_nxt;
    end
    if (rdy_b && vld_a_r) begin
      item_b_r <= item_b_nxt;
    end
    if (rdy_c && vld_b_r) begin
      item_c_r <= item_c_nxt;
    end
  end

  assign out_valid = vld_c_r;
  assign out_item  = item_c_r;

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_a_r |-> (item_a_r.t < LERP_FULL))
    else $error("segment percentage reached 100");

endmodule

FILE: rtl/core/todpt_tone.sv
// ----------------------------------------------------------------------------
// todpt_tone: channel tone stages and output register
// Multiplies each channel by its tone, divides by 31, clamps and bypasses.
// ----------------------------------------------------------------------------
module todpt_tone (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  todpt_pkg::tone_item_t in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output todpt_pkg::rgb_t       out_colour,
  output todpt_pkg::tcode_t     out_code,
  output logic                  out_last
);
  import todpt_pkg::*;

  typedef struct packed {
    rgb_t       colour;
    logic       last;
    logic       tint_en;
    tcode_t     code;
    logic [9:0] p_b;
    logic [9:0] p_g;
    logic [9:0] p_r;
  } prod_item_t;

  logic       vld_d_r, vld_e_r;
  logic       vld_d_nxt, vld_e_nxt;
  logic       rdy_d, rdy_e;
  prod_item_t item_d_r, item_d_nxt;
  rgb_t       colour_e_r, colour_e_nxt;
  tcode_t     code_e_r;
  logic       last_e_r;
  rgb_t       q;

  function automatic chan_t div31(logic [9:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'(RECIP_31);
    div31 = (p[R31_SHIFT +: 6] > 6'd31) ? 5'd31 : p[R31_SHIFT +: 5];
  endfunction

  assign rdy_e    = !vld_e_r || out_ready;
  assign rdy_d    = !vld_d_r || rdy_e;
  assign in_ready = rdy_d;

  always_comb begin
    item_d_nxt.colour  = in_item.colour;
    item_d_nxt.last    = in_item.last;
    item_d_nxt.tint_en = in_item.tint_en;
    item_d_nxt.code    = in_item.code;
    item_d_nxt.p_r     = 10'(in_item.colour.r) * 10'(in_item.tone.r);
    item_d_nxt.p_g     = 10'(in_item.colour.g) * 10'(in_item.tone.g);
    item_d_nxt.p_b     = 10'(in_item.colour.b) * 10'(in_item.tone.b);
  end

  always_comb begin
    q.r = div31(item_d_r.p_r);
    q.g = div31(item_d_r.p_g);
    q.b = div31(item_d_r.p_b);
    colour_e_nxt = item_d_r.tint_en ? q : item_d_r.colour;
  end

  always_comb begin
    vld_d_nxt = rdy_d ? in_valid : vld_d_r;
    vld_e_nxt = rdy_e ? vld_d_r  : vld_e_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d_r <= 1'b0;
      vld_e_r <= 1'b0;
    end else begin
      vld_d_r <= vld_d_nxt;
      vld_e_r <= vld_e_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_d && in_valid) begin
      item_d_r <= item_d_nxt;
    end
    if (rdy_e && vld_d_r) begin
      colour_e_r <= colour_e_nxt;
      code_e_r   <= item_d_r.code;
      last_e_r   <= item_d_r.last;
    end
  end

  assign out_valid  = vld_e_r;
  assign out_colour = colour_e_r;
  assign out_code   = code_e_r;
  assign out_last   = last_e_r;

  // a tone never brightens a channel
  a_no_gain: assert property (@(posedge clk) disable iff (!rst_n)
    vld_d_r |-> (q.r <= item_d_r.colour.r) && (q.g <= item_d_r.colour.g)
             && (q.b <= item_d_r.colour.b))
    else $error("tinted channel above source channel");

endmodule

FILE: rtl/core/time_of_day_palette_tint.sv
// ----------------------------------------------------------------------------
// time_of_day_palette_tint: RGB555 palette tint by time of day
// Keyframe lerp of the tint from the minute register, cave override, per
// channel tone scaling, with a bypass when tinting is off.
// ----------------------------------------------------------------------------
// pipeline: six register stages, seg, lerp a, b and c, tone d and e, with
//   out_* driven by the tone e register
// throughput: one colour per cycle unless out_tready stalls; every stage has
//   its own valid bit and fills bubbles while the output register waits on out_tready
// reset: pipeline empties, minute 0, tint on, cave and battle off
// config port always ready; writes to index 4 and up are dropped
module time_of_day_palette_tint (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [15:0]                        in_tdata,   // colour_in[14:0], zero pad
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [23:0]                        out_tdata,  // colour_out[14:0], time_code[16:15]
  output logic                               out_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [todpt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [todpt_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import todpt_pkg::*;

  minute_t    minute_r, minute_nxt;
  logic       tint_en_r, tint_en_nxt;
  logic       cave_r, cave_nxt;
  logic       battle_r, battle_nxt;
  mode_t      mode;
  logic       seg_valid, seg_ready;
  seg_item_t  seg_item;
  logic       lerp_valid, lerp_ready;
  tone_item_t lerp_item;
  rgb_t       res_colour;
  tcode_t     res_code;
  logic       res_last;

  assign cfg_ready = 1'b1;

  always_comb begin
    minute_nxt  = minute_r;
    tint_en_nxt = tint_en_r;
    cave_nxt    = cave_r;
    battle_nxt  = battle_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_MINUTE:  minute_nxt  = cfg_data;
        REG_TINT_EN: tint_en_nxt = cfg_data[0];
        REG_CAVE:    cave_nxt    = cfg_data[0];
        REG_BATTLE:  battle_nxt  = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minute_r  <= '0;
      tint_en_r <= 1'b1;
      cave_r    <= 1'b0;
      battle_r  <= 1'b0;
    end else begin
      minute_r  <= minute_nxt;
      tint_en_r <= tint_en_nxt;
      cave_r    <= cave_nxt;
      battle_r  <= battle_nxt;
    end
  end

  assign mode = '{tint_en: tint_en_r, cave: cave_r, battle: battle_r};

  todpt_seg u_seg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_colour (rgb_t'(in_tdata[14:0])),
    .in_last   (in_tlast),
    .in_mode   (mode),
    .minute    (minute_r),
    .out_valid (seg_valid),
    .out_ready (seg_ready),
    .out_item  (seg_item)
  );

  todpt_lerp u_lerp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (seg_valid),
    .in_ready  (seg_ready),
    .in_item   (seg_item),
    .out_valid (lerp_valid),
    .out_ready (lerp_ready),
    .out_item  (lerp_item)
  );

  todpt_tone u_tone (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (lerp_valid),
    .in_ready   (lerp_ready),
    .in_item    (lerp_item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_colour (res_colour),
    .out_code   (res_code),
    .out_last   (res_last)
  );

  assign out_tdata = {7'd0, res_code, res_colour};
  assign out_tlast = res_last;

  // with the output register empty nothing upstream can hold back a transaction
  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with output register empty");

endmodule
